### sv/cldq_pkg.sv
// Shared types, constants and helpers for the category limited dispatch queue.
// Used by cldq_cell, cldq_counters and category_limited_dispatch_queue.
package cldq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int NUM_CATEGORIES = 8;
    localparam int TYPE_W         = 2;
    localparam int TAG_W          = 8;
    localparam int CAT_W          = 3;
    localparam int CNT_W          = 8;
    localparam int CAT_SPAN       = 1 << CAT_W;
    localparam logic [CNT_W-1:0] MAX_INFLIGHT_RESET = CNT_W'(4);

    typedef enum logic [TYPE_W-1:0] {
        REQ_ENQUEUE  = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_CANCEL   = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [TAG_W-1:0]  request_tag;
        logic [CAT_W-1:0]  category_id;
    } in_word_t;

    typedef struct packed {
        logic             dispatch_valid;
        logic [TAG_W-1:0] dispatch_tag;
        logic [CAT_W-1:0] dispatch_category;
        logic             enqueue_dropped;
        logic             cancel_found;
    } out_word_t;

    // One queue slot as seen by its neighbors.
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [CAT_W-1:0] cat;
    } cldq_entry_t;

    // Search result rippling from the head of the queue toward the tail.
    typedef struct packed {
        logic             hit;
        logic [TAG_W-1:0] tag;
        logic [CAT_W-1:0] cat;
    } cldq_scan_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                append;
        logic                dispatch_scan;
        logic                cancel_scan;
        logic [TAG_W-1:0]    tag;
        logic [CAT_W-1:0]    cat;
        logic [CAT_SPAN-1:0] elig;
    } cldq_ctrl_t;

    // Counter update requests.
    typedef struct packed {
        logic             dec;
        logic [CAT_W-1:0] dec_cat;
        logic             inc;
        logic [CAT_W-1:0] inc_cat;
    } cldq_cnt_ctrl_t;

    // True when a category code names an existing category.
    function automatic logic cat_ok(logic [CAT_W-1:0] c);
        return int'(c) < NUM_CATEGORIES;
    endfunction

endpackage

### sv/cldq_cell.sv
// One slot of the wait queue: holds an entry, appends, searches and closes up.
// Depends on cldq_pkg.
module cldq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cldq_pkg::cldq_ctrl_t  ctrl,
    input  logic                prev_valid,
    input  cldq_pkg::cldq_entry_t next_entry,
    input  cldq_pkg::cldq_scan_t  scan_in,
    output cldq_pkg::cldq_entry_t entry,
    output cldq_pkg::cldq_scan_t  scan_out
);
    import cldq_pkg::*;

    logic             valid_reg, valid_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [CAT_W-1:0] cat_reg, cat_next;
    logic             self_hit;
    logic             shift;

    // This slot matches the current search.
    assign self_hit = valid_reg &&
                      ((ctrl.dispatch_scan && ctrl.elig[cat_reg]) ||
                       (ctrl.cancel_scan && (ctrl.tag == tag_reg)));

    // Slots at and after the first match take their right neighbor's entry.
    assign shift = scan_in.hit || self_hit;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        cat_next   = cat_reg;
        if (ctrl.append && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            tag_next   = ctrl.tag;
            cat_next   = ctrl.cat;
        end
        else if (shift)
        begin
            valid_next = next_entry.valid;
            tag_next   = next_entry.tag;
            cat_next   = next_entry.cat;
        end
    end

    // The first match wins; later slots only pass it along.
    always_comb
    begin
        if (scan_in.hit)
        begin
            scan_out = scan_in;
        end
        else if (self_hit)
        begin
            scan_out.hit = 1'b1;
            scan_out.tag = tag_reg;
            scan_out.cat = cat_reg;
        end
        else
        begin
            scan_out = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset: it is only read while valid.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        cat_reg <= cat_next;
    end

    assign entry.valid = valid_reg;
    assign entry.tag   = tag_reg;
    assign entry.cat   = cat_reg;

endmodule

### sv/cldq_counters.sv
// Per-category in-flight counters and the eligibility mask derived from them.
// Depends on cldq_pkg.
module cldq_counters (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cldq_pkg::cldq_cnt_ctrl_t cnt_ctrl,
    input  logic [cldq_pkg::CNT_W-1:0] max_inflight,
    output logic [cldq_pkg::CAT_SPAN-1:0] elig
);
    import cldq_pkg::*;

    logic [CNT_W-1:0] cnt_reg  [CAT_SPAN];
    logic [CNT_W-1:0] cnt_next [CAT_SPAN];

    for (genvar c = 0; c < CAT_SPAN; c++)
    begin : g_cnt
        logic dec_hit;
        logic inc_hit;

        // A completion at zero leaves the counter alone.
        assign dec_hit = cnt_ctrl.dec && (cnt_ctrl.dec_cat == CAT_W'(c)) &&
                         (cnt_reg[c] != '0);
        assign inc_hit = cnt_ctrl.inc && (cnt_ctrl.inc_cat == CAT_W'(c));

        always_comb
        begin
            cnt_next[c] = cnt_reg[c];
            if (inc_hit && !dec_hit)
            begin
                cnt_next[c] = cnt_reg[c] + CNT_W'(1);
            end
            else if (dec_hit && !inc_hit)
            begin
                cnt_next[c] = cnt_reg[c] - CNT_W'(1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[c] <= '0;
            end
            else
            begin
                cnt_reg[c] <= cnt_next[c];
            end
        end

        // A category may take one more dispatch while below the limit.
        assign elig[c] = cat_ok(CAT_W'(c)) && (cnt_reg[c] < max_inflight);
    end

endmodule

### sv/category_limited_dispatch_queue.sv
// Top level of the category limited dispatch queue.
// Depends on cldq_pkg, cldq_cell and cldq_counters.
//
// Usage:
//   An input word (enqueue, completion or cancel) is taken at a rising edge
//   where start is high and busy is low. busy is high while the block is in
//   its search state, so no new word is taken until the last one is done.
//   At the accepting edge an enqueue is appended to the first free cell and a
//   completion decrements its category counter. In the following cycle the
//   search ripples once through the row of QUEUE_DEPTH cells: the oldest
//   eligible entry (dispatch) or the first tag match (cancel) is found, and
//   every cell from that point on takes its right neighbor's entry.
//   The result word appears on result with done high for exactly one cycle,
//   registered at the end of the search cycle; every word gives one result.
//   The receiver cannot stall, so nothing is held back. max_inflight is
//   written through cfg_we and cfg_data; the user must write it only while
//   the block is idle, which the block itself does not enforce. It resets
//   to 4.
//   Reset empties the queue, clears all in-flight counters and returns the
//   block to idle at once; no clearing pass is needed.
module category_limited_dispatch_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  cldq_pkg::in_word_t         in_word,
    output logic                       done,
    output cldq_pkg::out_word_t        result,
    input  logic                       cfg_we,
    input  logic [cldq_pkg::CNT_W-1:0] cfg_data
);
    import cldq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t            state_reg;
    logic [TYPE_W-1:0] kind_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              dropped_reg;
    logic              done_reg;
    out_word_t         result_reg;
    logic [CNT_W-1:0]  max_reg;

    logic           accept;
    logic           dispatch_scan;
    logic           cancel_scan;
    logic           dropped;
    cldq_ctrl_t     ctrl;
    cldq_cnt_ctrl_t cnt_ctrl;
    logic [CAT_SPAN-1:0] elig;
    out_word_t      result_next;

    cldq_entry_t entries [QUEUE_DEPTH];
    cldq_scan_t  scans   [QUEUE_DEPTH+1];

    assign accept        = start && (state_reg == ST_IDLE);
    assign dispatch_scan = (state_reg == ST_SCAN) &&
                           ((kind_reg == REQ_ENQUEUE) || (kind_reg == REQ_COMPLETE));
    assign cancel_scan   = (state_reg == ST_SCAN) && (kind_reg == REQ_CANCEL);

    // An enqueue is dropped when the tail cell is taken or the category is unknown.
    assign dropped = (in_word.req_type == REQ_ENQUEUE) &&
                     (!cat_ok(in_word.category_id) || entries[QUEUE_DEPTH-1].valid);

    // Broadcast control for the row of cells.
    assign ctrl.append        = accept && (in_word.req_type == REQ_ENQUEUE) &&
                                cat_ok(in_word.category_id);
    assign ctrl.dispatch_scan = dispatch_scan;
    assign ctrl.cancel_scan   = cancel_scan;
    assign ctrl.tag           = accept ? in_word.request_tag : tag_reg;
    assign ctrl.cat           = in_word.category_id;
    assign ctrl.elig          = elig;

    // Counter updates: decrement on acceptance, increment on dispatch.
    assign cnt_ctrl.dec     = accept && (in_word.req_type == REQ_COMPLETE) &&
                              cat_ok(in_word.category_id);
    assign cnt_ctrl.dec_cat = in_word.category_id;
    assign cnt_ctrl.inc     = dispatch_scan && scans[QUEUE_DEPTH].hit;
    assign cnt_ctrl.inc_cat = scans[QUEUE_DEPTH].cat;

    cldq_counters u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .cnt_ctrl     (cnt_ctrl),
        .max_inflight (max_reg),
        .elig         (elig)
    );

    // The row of cells; the head is cell 0.
    assign scans[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic        prev_valid;
        cldq_entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = entries[i-1].valid;
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = entries[i+1];
        end

        cldq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_valid),
            .next_entry (next_entry),
            .scan_in    (scans[i]),
            .entry      (entries[i]),
            .scan_out   (scans[i+1])
        );
    end

    // Result word assembled from the end of the search chain.
    always_comb
    begin
        result_next                   = '0;
        result_next.dispatch_valid    = dispatch_scan && scans[QUEUE_DEPTH].hit;
        result_next.enqueue_dropped   = dropped_reg;
        result_next.cancel_found      = cancel_scan && scans[QUEUE_DEPTH].hit;
        if (dispatch_scan && scans[QUEUE_DEPTH].hit)
        begin
            result_next.dispatch_tag      = scans[QUEUE_DEPTH].tag;
            result_next.dispatch_category = scans[QUEUE_DEPTH].cat;
        end
    end

    // Sequencer, captured item and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= '0;
            tag_reg     <= '0;
            dropped_reg <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg    <= in_word.req_type;
                        tag_reg     <= in_word.request_tag;
                        dropped_reg <= dropped;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    result_reg <= result_next;
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_INFLIGHT_RESET;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_data;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
